[rtl/core/gpu_lane_register_file_top_defines.svh]
// Assertion macros shared by the lane register file RTL.
// Expects signals named clk and rst_n in the scope of use.
`ifndef GPU_LANE_REGISTER_FILE_TOP_DEFINES_SVH
`define GPU_LANE_REGISTER_FILE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GLRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GLRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/glrf_pkg.sv]
// Types, constants and helper functions of the lane register file.
// Used by the channel interfaces, the scalar bank and the top level.
package glrf_pkg;

    localparam int DATA_W        = 32;
    localparam int SIDX_W        = 8;
    localparam int SCALAR_COUNT  = 256;
    localparam int LANE_W        = 6;
    localparam int FUNC_W        = 3;

    localparam logic [SIDX_W-1:0] IDX_VCC_LO  = 8'd106;
    localparam logic [SIDX_W-1:0] IDX_VCC_HI  = 8'd107;
    localparam logic [SIDX_W-1:0] IDX_EXEC_LO = 8'd126;
    localparam logic [SIDX_W-1:0] IDX_EXEC_HI = 8'd127;
    localparam logic [SIDX_W-1:0] IDX_VCCZ    = 8'd251;
    localparam logic [SIDX_W-1:0] IDX_EXECZ   = 8'd252;

    typedef enum logic [FUNC_W-1:0] {
        FN_SREAD  = 3'd0,
        FN_SWRITE = 3'd1,
        FN_VREAD  = 3'd2,
        FN_VWRITE = 3'd3,
        FN_LWRITE = 3'd4,
        FN_LREAD  = 3'd5
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic              en;
        logic [SIDX_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } swr_t;

    // Reserved scalar indices; bit 8 marks an index past the top of the file.
    function automatic logic is_reserved(input logic [SIDX_W:0] idx);
        logic res;
        res = idx[SIDX_W];
        if (idx == 9'd104 || idx == 9'd105 || idx == 9'd125 || idx == 9'd254)
        begin
            res = 1'b1;
        end
        if (idx >= 9'd209 && idx <= 9'd239)
        begin
            res = 1'b1;
        end
        if (idx >= 9'd248 && idx <= 9'd250)
        begin
            res = 1'b1;
        end
        return res;
    endfunction

endpackage

[rtl/core/glrf_channels.sv]
// Valid/ready channel interfaces of the lane register file.
// Depends on glrf_pkg for field widths.
interface glrf_in_if;
    logic                               valid;
    logic                               ready;
    logic [glrf_pkg::FUNC_W-1:0]        func;
    logic [glrf_pkg::SIDX_W-1:0]        reg_index;
    logic [glrf_pkg::DATA_W-1:0]        write_data;

    modport source (output valid, func, reg_index, write_data, input ready);
    modport sink   (input valid, func, reg_index, write_data, output ready);
endinterface

interface glrf_out_if;
    logic                               valid;
    logic                               ready;
    logic [glrf_pkg::DATA_W-1:0]        read_data;
    logic                               illegal_index;

    modport source (output valid, read_data, illegal_index, input ready);
    modport sink   (input valid, read_data, illegal_index, output ready);
endinterface

interface glrf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [glrf_pkg::LANE_W-1:0]        data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/core/glrf_sbank.sv]
// Scalar register bank: 256 x 32 synchronous memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
module glrf_sbank
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [glrf_pkg::SIDX_W-1:0]   rd_addr,
    input  glrf_pkg::swr_t                wr,
    output logic [glrf_pkg::DATA_W-1:0]   rd_data
);

    logic [glrf_pkg::DATA_W-1:0]        scalar_mem [glrf_pkg::SCALAR_COUNT];
    logic [glrf_pkg::SCALAR_COUNT-1:0]  valid_reg;
    logic [glrf_pkg::DATA_W-1:0]        rd_mem_reg;
    logic                               rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            scalar_mem[wr.addr] <= wr.data;
        end
        rd_mem_reg <= scalar_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

[rtl/core/gpu_lane_register_file_top.sv]
// Lane register file top level: decode, scalar and vector banks, result register.
// Depends on glrf_pkg, the channel interfaces and glrf_sbank.
//
//   channel | dir | payload                              | accepted when
//   cfg     | in  | data (lane id)                       | valid & ready
//   req     | in  | func, reg_index, write_data          | valid & ready
//   rsp     | out | read_data, illegal_index             | valid & ready
//
// Each item issues the synchronous bank read on acceptance and then goes on to
// form the result and write back. Lane bit writes use that same pass for the
// read-modify-write. A new item is taken while an earlier result still waits
// in the output register; the execute cycle holds only while that register is
// full. Reset clears control state, the scalar valid bits and the pair flags.
`include "gpu_lane_register_file_top_defines.svh"

module gpu_lane_register_file_top
#(
    parameter int VECTOR_COUNT = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    glrf_cfg_if.sink     cfg,
    glrf_in_if.sink      req,
    glrf_out_if.source   rsp
);

    localparam int VIDX_W = (VECTOR_COUNT > 1) ? $clog2(VECTOR_COUNT) : 1;

    glrf_pkg::state_t                   state_reg;
    glrf_pkg::state_t                   state_next;
    logic [glrf_pkg::LANE_W-1:0]        lane_id_reg;

    logic [glrf_pkg::FUNC_W-1:0]        op_func_reg;
    logic [glrf_pkg::SIDX_W-1:0]        op_addr_reg;
    logic [glrf_pkg::DATA_W-1:0]        op_data_reg;
    logic [4:0]                         op_pos_reg;
    logic                               op_bad_reg;
    logic                               op_vok_reg;

    logic                               nz_vcc_lo_reg;
    logic                               nz_vcc_hi_reg;
    logic                               nz_exec_lo_reg;
    logic                               nz_exec_hi_reg;

    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    logic [glrf_pkg::DATA_W-1:0]        rsp_data_reg;
    logic                               rsp_illegal_reg;

    logic [glrf_pkg::DATA_W-1:0]        vector_mem [VECTOR_COUNT];
    logic [glrf_pkg::DATA_W-1:0]        v_rd_reg;

    logic                               accept;
    logic                               fire;
    logic                               is_lane_op;
    logic                               is_scalar_op;
    logic [glrf_pkg::SIDX_W:0]          target;
    logic [glrf_pkg::SIDX_W-1:0]        s_rd_addr;
    logic [VIDX_W-1:0]                  v_rd_addr;
    logic [glrf_pkg::DATA_W-1:0]        s_rd_data;
    logic [glrf_pkg::DATA_W-1:0]        sread_val;
    logic [glrf_pkg::DATA_W-1:0]        mask;
    logic [glrf_pkg::DATA_W-1:0]        result;
    logic                               v_we;
    glrf_pkg::swr_t                     swr;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == glrf_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign fire      = (state_reg == glrf_pkg::ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign is_lane_op   = (req.func == glrf_pkg::FN_LWRITE) || (req.func == glrf_pkg::FN_LREAD);
    assign is_scalar_op = is_lane_op || (req.func == glrf_pkg::FN_SREAD)
                          || (req.func == glrf_pkg::FN_SWRITE);
    assign target       = {1'b0, req.reg_index}
                          + {{glrf_pkg::SIDX_W{1'b0}}, is_lane_op & lane_id_reg[5]};

    assign s_rd_addr = accept ? target[glrf_pkg::SIDX_W-1:0] : op_addr_reg;
    assign v_rd_addr = accept ? req.reg_index[VIDX_W-1:0] : op_addr_reg[VIDX_W-1:0];

    glrf_sbank u_sbank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (s_rd_addr),
        .wr      (swr),
        .rd_data (s_rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vector_mem[op_addr_reg[VIDX_W-1:0]] <= op_data_reg;
        end
        v_rd_reg <= vector_mem[v_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_func_reg <= req.func;
            op_addr_reg <= target[glrf_pkg::SIDX_W-1:0];
            op_data_reg <= req.write_data;
            op_pos_reg  <= lane_id_reg[4:0];
            op_bad_reg  <= is_scalar_op && glrf_pkg::is_reserved(target);
            op_vok_reg  <= ({1'b0, req.reg_index} < 9'(VECTOR_COUNT));
        end
        if (fire)
        begin
            rsp_data_reg    <= result;
            rsp_illegal_reg <= op_bad_reg;
        end
    end

    // The zero-flag indices read as values computed from their register pairs.
    always_comb
    begin
        if (op_addr_reg == glrf_pkg::IDX_VCCZ)
        begin
            sread_val = {31'd0, !(nz_vcc_lo_reg || nz_vcc_hi_reg)};
        end
        else if (op_addr_reg == glrf_pkg::IDX_EXECZ)
        begin
            sread_val = {31'd0, !(nz_exec_lo_reg || nz_exec_hi_reg)};
        end
        else
        begin
            sread_val = s_rd_data;
        end
    end

    assign mask = 32'd1 << op_pos_reg;

    always_comb
    begin
        result   = '0;
        v_we     = 1'b0;
        swr.en   = 1'b0;
        swr.addr = op_addr_reg;
        swr.data = op_data_reg;
        case (glrf_pkg::func_t'(op_func_reg))
            glrf_pkg::FN_SREAD:
            begin
                result = op_bad_reg ? '0 : sread_val;
            end
            glrf_pkg::FN_SWRITE:
            begin
                swr.en = fire && !op_bad_reg;
            end
            glrf_pkg::FN_VREAD:
            begin
                result = op_vok_reg ? v_rd_reg : '0;
            end
            glrf_pkg::FN_VWRITE:
            begin
                v_we = fire && op_vok_reg;
            end
            glrf_pkg::FN_LWRITE:
            begin
                swr.en   = fire && !op_bad_reg;
                swr.data = (op_data_reg != '0) ? (sread_val | mask) : (sread_val & ~mask);
            end
            glrf_pkg::FN_LREAD:
            begin
                result = op_bad_reg ? '0 : {31'd0, sread_val[op_pos_reg]};
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            glrf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = glrf_pkg::ST_EXEC;
                end
            end
            glrf_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    state_next     = glrf_pkg::ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = glrf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= glrf_pkg::ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            lane_id_reg    <= '0;
            nz_vcc_lo_reg  <= 1'b0;
            nz_vcc_hi_reg  <= 1'b0;
            nz_exec_lo_reg <= 1'b0;
            nz_exec_hi_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                lane_id_reg <= cfg.data;
            end
            if (swr.en)
            begin
                if (swr.addr == glrf_pkg::IDX_VCC_LO)
                begin
                    nz_vcc_lo_reg <= (swr.data != '0);
                end
                if (swr.addr == glrf_pkg::IDX_VCC_HI)
                begin
                    nz_vcc_hi_reg <= (swr.data != '0);
                end
                if (swr.addr == glrf_pkg::IDX_EXEC_LO)
                begin
                    nz_exec_lo_reg <= (swr.data != '0);
                end
                if (swr.addr == glrf_pkg::IDX_EXEC_HI)
                begin
                    nz_exec_hi_reg <= (swr.data != '0);
                end
            end
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_data     = rsp_data_reg;
    assign rsp.illegal_index = rsp_illegal_reg;

    `GLRF_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == glrf_pkg::ST_EXEC, "accepted item did not enter execute")
    `GLRF_ASSERT_NOW(a_write_only_on_fire, swr.en || v_we, fire, "bank written outside the execute cycle")
    `GLRF_ASSERT_NOW(a_no_write_when_illegal, fire && op_bad_reg, !swr.en && !v_we, "reserved index changed state")
    `GLRF_ASSERT_NOW(a_illegal_reads_zero, rsp_valid_reg && rsp_illegal_reg, rsp_data_reg == '0, "illegal result carries data")

endmodule

[dv/glrf_reply_checker.sv]
`timescale 1ns / 100ps
// Result checker for the lane register file: predicts each result from accepted items.
// Watches the glrf_channels interfaces and uses types and constants from glrf_pkg.
module glrf_reply_checker
#(
    parameter int VECTOR_COUNT = 256
)
(
    input  logic clk,
    input  logic rst_n,
    glrf_cfg_if  cfg,
    glrf_in_if   req,
    glrf_out_if  rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam logic [glrf_pkg::SIDX_W:0] RSV_VCC_GAP_LO = 9'd104;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_VCC_GAP_HI = 9'd105;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_EXEC_GAP   = 9'd125;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_BAND_LO    = 9'd209;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_BAND_HI    = 9'd239;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_HIGH_LO    = 9'd248;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_HIGH_HI    = 9'd250;
    localparam logic [glrf_pkg::SIDX_W:0] RSV_TOP        = 9'd254;

    typedef struct packed {
        logic [glrf_pkg::DATA_W-1:0] read_data;
        logic                        illegal_index;
    } reply_t;

    logic [glrf_pkg::DATA_W-1:0] scalar_file [glrf_pkg::SCALAR_COUNT];
    logic [glrf_pkg::DATA_W-1:0] vector_file [VECTOR_COUNT];
    logic [glrf_pkg::LANE_W-1:0] lane_id;
    reply_t                      pending_replies [$];
    reply_t                      wanted;
    int                          mismatch_count = 0;
    int                          open_count = 0;

    assign mismatches  = mismatch_count;
    assign outstanding = open_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic logic scalar_slot_reserved(input logic [glrf_pkg::SIDX_W:0] slot);
        return slot[glrf_pkg::SIDX_W] || (slot inside {RSV_VCC_GAP_LO, RSV_VCC_GAP_HI,
            RSV_EXEC_GAP, RSV_TOP, [RSV_BAND_LO:RSV_BAND_HI], [RSV_HIGH_LO:RSV_HIGH_HI]});
    endfunction

    // The two flag indices read back what their register pair holds, not what is stored.
    function automatic logic [glrf_pkg::DATA_W-1:0] scalar_value(
        input logic [glrf_pkg::SIDX_W-1:0] slot);
        if (slot == glrf_pkg::IDX_VCCZ)
        begin
            return (scalar_file[glrf_pkg::IDX_VCC_LO] == '0
                    && scalar_file[glrf_pkg::IDX_VCC_HI] == '0) ? 32'd1 : 32'd0;
        end
        if (slot == glrf_pkg::IDX_EXECZ)
        begin
            return (scalar_file[glrf_pkg::IDX_EXEC_LO] == '0
                    && scalar_file[glrf_pkg::IDX_EXEC_HI] == '0) ? 32'd1 : 32'd0;
        end
        return scalar_file[slot];
    endfunction

    function automatic void scalar_store(input logic [glrf_pkg::SIDX_W-1:0] slot,
                                         input logic [glrf_pkg::DATA_W-1:0] value);
        scalar_file[slot] = value;
        if (slot == glrf_pkg::IDX_VCC_LO || slot == glrf_pkg::IDX_VCC_HI)
        begin
            scalar_file[glrf_pkg::IDX_VCCZ] = scalar_value(glrf_pkg::IDX_VCCZ);
        end
        if (slot == glrf_pkg::IDX_EXEC_LO || slot == glrf_pkg::IDX_EXEC_HI)
        begin
            scalar_file[glrf_pkg::IDX_EXECZ] = scalar_value(glrf_pkg::IDX_EXECZ);
        end
    endfunction

    function automatic reply_t lane_access_result(input logic [glrf_pkg::FUNC_W-1:0] fn,
                                                  input logic [glrf_pkg::SIDX_W-1:0] slot,
                                                  input logic [glrf_pkg::DATA_W-1:0] wdata);
        reply_t                      reply;
        logic [glrf_pkg::SIDX_W:0]   target;
        logic [glrf_pkg::DATA_W-1:0] lane_mask;
        logic [glrf_pkg::DATA_W-1:0] current;
        reply     = '0;
        target    = {1'b0, slot} + 9'(lane_id[glrf_pkg::LANE_W-1]);
        lane_mask = 32'd1 << lane_id[4:0];
        case (fn)
            glrf_pkg::FN_SREAD:
            begin
                if (scalar_slot_reserved({1'b0, slot}))
                begin
                    reply.illegal_index = 1'b1;
                end
                else
                begin
                    reply.read_data = scalar_value(slot);
                end
            end
            glrf_pkg::FN_SWRITE:
            begin
                if (scalar_slot_reserved({1'b0, slot}))
                begin
                    reply.illegal_index = 1'b1;
                end
                else
                begin
                    scalar_store(slot, wdata);
                end
            end
            glrf_pkg::FN_VREAD:
            begin
                if (int'(slot) < VECTOR_COUNT)
                begin
                    reply.read_data = vector_file[slot];
                end
            end
            glrf_pkg::FN_VWRITE:
            begin
                if (int'(slot) < VECTOR_COUNT)
                begin
                    vector_file[slot] = wdata;
                end
            end
            glrf_pkg::FN_LWRITE, glrf_pkg::FN_LREAD:
            begin
                if (scalar_slot_reserved(target))
                begin
                    reply.illegal_index = 1'b1;
                end
                else if (fn == glrf_pkg::FN_LWRITE)
                begin
                    current = scalar_value(target[glrf_pkg::SIDX_W-1:0]);
                    scalar_store(target[glrf_pkg::SIDX_W-1:0],
                                 (wdata != '0) ? (current | lane_mask) : (current & ~lane_mask));
                end
                else
                begin
                    reply.read_data =
                        ((scalar_value(target[glrf_pkg::SIDX_W-1:0]) & lane_mask) != '0)
                        ? 32'd1 : 32'd0;
                end
            end
            default:
            begin
            end
        endcase
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (scalar_file[i])
            begin
                scalar_file[i] = '0;
            end
            foreach (vector_file[i])
            begin
                vector_file[i] = '0;
            end
            lane_id = '0;
            pending_replies.delete();
            open_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    report_mismatch($sformatf("result %h/%0b with no item waiting",
                                              rsp.read_data, rsp.illegal_index));
                end
                else
                begin
                    wanted = pending_replies.pop_front();
                    if (rsp.read_data !== wanted.read_data)
                    begin
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  rsp.read_data, wanted.read_data));
                    end
                    if (rsp.illegal_index !== wanted.illegal_index)
                    begin
                        report_mismatch($sformatf("illegal_index %b, expected %b",
                                                  rsp.illegal_index, wanted.illegal_index));
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                pending_replies.push_back(
                    lane_access_result(req.func, req.reg_index, req.write_data));
            end
            if (cfg.valid && cfg.ready)
            begin
                lane_id = cfg.data;
            end
            open_count = pending_replies.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the lane register file testbench: clock, reset, stimulus and verdict.
// Needs glrf_pkg, the channel interfaces, the RTL top and glrf_reply_checker.
module testbench;

    localparam int VECTOR_COUNT = 256;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_OFF_CYCLES = 80;

    localparam logic [glrf_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [glrf_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_ZERO         = 8'd0;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_PRE_VCC_GAP  = 8'd103;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_VCC_GAP      = 8'd104;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_PRE_EXEC_GAP = 8'd124;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_PRE_HIGH_RSV = 8'd247;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_HIGH_RSV_HI  = 8'd250;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_RSV_TOP      = 8'd254;
    localparam logic [glrf_pkg::SIDX_W-1:0] IDX_LAST         = 8'd255;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    bit   source_gaps = 1'b0;
    bit   sink_stalls = 1'b0;
    bit   hold_off_request = 1'b0;
    bit   vector_written [VECTOR_COUNT];
    logic [glrf_pkg::SIDX_W-1:0] written_slots [$];

    glrf_cfg_if cfg_ch ();
    glrf_in_if  req_ch ();
    glrf_out_if rsp_ch ();

    gpu_lane_register_file_top #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    glrf_reply_checker #(
        .VECTOR_COUNT (VECTOR_COUNT)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (sink_stalls && $urandom_range(0, 9) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic issue(input logic [glrf_pkg::FUNC_W-1:0] fn,
                         input logic [glrf_pkg::SIDX_W-1:0] slot,
                         input logic [glrf_pkg::DATA_W-1:0] wdata);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= fn;
        req_ch.reg_index  <= slot;
        req_ch.write_data <= wdata;
        if (fn == glrf_pkg::FN_VWRITE && !vector_written[slot])
        begin
            vector_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
        do @(posedge clk); while (!req_ch.ready);
        if (source_gaps && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic wait_for_replies();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_lane(input logic [glrf_pkg::LANE_W-1:0] lane);
        cfg_ch.data  <= lane;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int                          pick;
        logic [glrf_pkg::FUNC_W-1:0] fn;
        logic [glrf_pkg::SIDX_W-1:0] slot;
        logic [glrf_pkg::DATA_W-1:0] wdata;
        logic [glrf_pkg::LANE_W-1:0] lane;
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= '0;
        req_ch.reg_index  <= '0;
        req_ch.write_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(glrf_pkg::FN_SREAD, IDX_ZERO, '0);
        issue(glrf_pkg::FN_SWRITE, IDX_ZERO, '1);
        issue(glrf_pkg::FN_SREAD, IDX_ZERO, '0);
        issue(glrf_pkg::FN_SREAD, glrf_pkg::IDX_VCCZ, '0);
        issue(glrf_pkg::FN_SREAD, glrf_pkg::IDX_EXECZ, '0);
        issue(glrf_pkg::FN_SWRITE, glrf_pkg::IDX_VCC_HI, 32'h8000_0000);
        issue(glrf_pkg::FN_SREAD, glrf_pkg::IDX_VCCZ, '0);
        issue(glrf_pkg::FN_SWRITE, glrf_pkg::IDX_VCCZ, 32'h0000_0005);
        issue(glrf_pkg::FN_SREAD, glrf_pkg::IDX_VCCZ, '0);
        issue(glrf_pkg::FN_SWRITE, IDX_VCC_GAP, '1);
        issue(glrf_pkg::FN_SREAD, IDX_RSV_TOP, '0);
        issue(glrf_pkg::FN_VWRITE, IDX_ZERO, 32'hDEAD_BEEF);
        issue(glrf_pkg::FN_VWRITE, IDX_LAST, '1);
        issue(glrf_pkg::FN_VREAD, IDX_LAST, '0);
        issue(glrf_pkg::FN_VREAD, IDX_ZERO, '0);
        issue(glrf_pkg::FN_LWRITE, glrf_pkg::IDX_EXEC_LO, 32'h0000_0100);
        issue(glrf_pkg::FN_LREAD, glrf_pkg::IDX_EXEC_LO, '0);
        issue(glrf_pkg::FN_SREAD, glrf_pkg::IDX_EXECZ, '0);
        issue(glrf_pkg::FN_LWRITE, glrf_pkg::IDX_EXECZ, 32'h0000_0001);
        issue(FN_SPARE_6, IDX_LAST, '1);
        issue(FN_SPARE_7, IDX_ZERO, '1);
        wait_for_replies();
        set_lane(6'd63);
        issue(glrf_pkg::FN_LWRITE, IDX_LAST, 32'h0000_0001);
        issue(glrf_pkg::FN_LREAD, IDX_PRE_VCC_GAP, '0);
        issue(glrf_pkg::FN_LWRITE, glrf_pkg::IDX_VCC_LO, 32'h0000_0001);
        issue(glrf_pkg::FN_LREAD, glrf_pkg::IDX_VCC_LO, '0);
        issue(glrf_pkg::FN_LREAD, IDX_HIGH_RSV_HI, '0);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_for_replies();
            case (phase)
                0: lane = 6'd31;
                1: lane = 6'd32;
                2: lane = 6'd0;
                4: lane = 6'd63;
                default: lane = 6'($urandom_range(0, 63));
            endcase
            set_lane(lane);
            source_gaps      = (phase != 3) && (phase != 5);
            sink_stalls      = (phase != 5);
            hold_off_request = (phase == 3);
            for (int n = 0; n < 125; n++)
            begin
                if (phase == 2 && n == 60)
                begin
                    wait_for_replies();
                end
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 7))
                    0: wdata = '0;
                    1: wdata = '1;
                    2: wdata = 32'd1 << $urandom_range(0, 31);
                    default: wdata = $urandom;
                endcase
                case ($urandom_range(0, 19))
                    0: slot = glrf_pkg::IDX_VCC_LO;
                    1: slot = glrf_pkg::IDX_VCC_HI;
                    2: slot = glrf_pkg::IDX_EXEC_LO;
                    3: slot = glrf_pkg::IDX_EXEC_HI;
                    4: slot = glrf_pkg::IDX_VCCZ;
                    5: slot = glrf_pkg::IDX_EXECZ;
                    6: slot = IDX_LAST;
                    7: slot = IDX_HIGH_RSV_HI;
                    8: slot = IDX_PRE_HIGH_RSV;
                    9: slot = IDX_PRE_VCC_GAP;
                    10: slot = IDX_PRE_EXEC_GAP;
                    11: slot = 8'($urandom_range(209, 239));
                    12, 13, 14, 15: slot = 8'($urandom_range(0, 15));
                    default: slot = 8'($urandom_range(0, 255));
                endcase
                if (pick < 18)
                begin
                    fn = glrf_pkg::FN_SREAD;
                end
                else if (pick < 36)
                begin
                    fn = glrf_pkg::FN_SWRITE;
                end
                else if (pick < 50)
                begin
                    fn = glrf_pkg::FN_VREAD;
                end
                else if (pick < 62)
                begin
                    fn = glrf_pkg::FN_VWRITE;
                end
                else if (pick < 80)
                begin
                    fn = glrf_pkg::FN_LWRITE;
                end
                else if (pick < 96)
                begin
                    fn = glrf_pkg::FN_LREAD;
                end
                else if (pick < 98)
                begin
                    fn = FN_SPARE_6;
                end
                else
                begin
                    fn = FN_SPARE_7;
                end
                if (fn == glrf_pkg::FN_VWRITE)
                begin
                    slot = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 15));
                end
                if (fn == glrf_pkg::FN_VREAD)
                begin
                    if (written_slots.size() == 0)
                    begin
                        fn = glrf_pkg::FN_VWRITE;
                    end
                    else
                    begin
                        slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
                    end
                end
                if (fn == glrf_pkg::FN_LWRITE && $urandom_range(0, 1) == 0)
                begin
                    wdata = '0;
                end
                issue(fn, slot, wdata);
            end
        end

        wait_for_replies();
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
